/* hw/rtl/spq_pkg.sv */
package spq_pkg;

    // opcode carried on the input tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam int PRIO_W   = 16;
    localparam int DATA_W   = 32;
    localparam int ERR_W    = 2;

    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

    typedef logic signed [PRIO_W-1:0] prio_t;

    typedef struct packed {
        logic             load;
        logic             push;
        logic             pop;
        logic [ERR_W-1:0] err;
    } spq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } spq_stat_t;

endpackage

/* hw/rtl/spq_ctrl.sv */
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_opcode,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t  cmd
);
    import spq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign out_valid = (state_reg == S_HOLD);
    // result register frees up in the same cycle it is taken
    assign in_ready  = (state_reg == S_IDLE) || out_ready;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        cmd.load = accept;
        cmd.push = 1'b0;
        cmd.pop  = 1'b0;
        cmd.err  = ERR_NONE;
        if (accept)
        begin
            unique case (in_opcode)
                OP_PUSH:
                begin
                    cmd.push = !stat.full;
                    cmd.err  = stat.full ? ERR_FULL : ERR_NONE;
                end
                OP_POP:
                begin
                    cmd.pop = !stat.empty;
                    cmd.err = stat.empty ? ERR_EMPTY : ERR_NONE;
                end
                default:
                begin
                    cmd.err = ERR_NONE;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        priority if (accept)
            state_next = S_HOLD;
        else if (out_ready)
            state_next = S_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_push_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (cmd.err == ERR_NONE && !cmd.pop))
        else $error("push issued together with an error or a pop");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_opcode == OP_PUSH && stat.full) |-> (!cmd.push && cmd.err == ERR_FULL))
        else $error("push into full queue not dropped");

    a_hold_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid)
        else $error("result not presented after a transfer");

endmodule

/* hw/rtl/spq_datapath.sv */
module spq_datapath #(
    parameter int CAPACITY      = 16,
    parameter int PAYLOAD_WIDTH = 32,
    parameter int CNT_W         = $clog2(CAPACITY + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  spq_pkg::spq_cmd_t          cmd,
    input  logic [spq_pkg::DATA_W-1:0] new_payload,
    input  spq_pkg::prio_t             new_priority,
    output spq_pkg::spq_stat_t         stat,
    output logic                       head_valid,
    output logic [spq_pkg::DATA_W-1:0] head_payload,
    output spq_pkg::prio_t             head_priority,
    output logic [CNT_W-1:0]           entry_count,
    output logic [spq_pkg::ERR_W-1:0]  op_error
);
    import spq_pkg::*;

    logic [PAYLOAD_WIDTH-1:0] pay_reg [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0] pay_next [CAPACITY];
    prio_t                    pri_reg [CAPACITY];
    prio_t                    pri_next [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0] sh_pay [CAPACITY];
    prio_t                    sh_pri [CAPACITY];
    logic [PAYLOAD_WIDTH-1:0] up_pay [CAPACITY];
    prio_t                    up_pri [CAPACITY];
    logic [CAPACITY-1:0]      le;
    logic [CAPACITY-1:0]      at_pos;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [PAYLOAD_WIDTH-1:0] ins_pay;
    logic [DATA_W-1:0]        head_pay_ext;

    logic                     head_valid_reg;
    logic [DATA_W-1:0]        head_payload_reg;
    prio_t                    head_priority_reg;
    logic [CNT_W-1:0]         entry_count_reg;
    logic [ERR_W-1:0]         op_error_reg;

    generate
        if (PAYLOAD_WIDTH > DATA_W)
        begin : g_wide
            assign ins_pay      = {{(PAYLOAD_WIDTH-DATA_W){1'b0}}, new_payload};
            assign head_pay_ext = pay_next[0][DATA_W-1:0];
        end
        else if (PAYLOAD_WIDTH == DATA_W)
        begin : g_equal
            assign ins_pay      = new_payload;
            assign head_pay_ext = pay_next[0];
        end
        else
        begin : g_narrow
            assign ins_pay      = new_payload[PAYLOAD_WIDTH-1:0];
            assign head_pay_ext = {{(DATA_W-PAYLOAD_WIDTH){1'b0}}, pay_next[0]};
        end
    endgenerate

    // every cell compares against the new priority at once; le is a thermometer
    generate
        for (genvar g = 0; g < CAPACITY; g++)
        begin : g_cell
            assign le[g] = (CNT_W'(g) < count_reg) && (pri_reg[g] <= new_priority);
            if (g == 0)
            begin : g_first
                assign at_pos[g] = !le[g];
                assign sh_pay[g] = ins_pay;
                assign sh_pri[g] = new_priority;
            end
            else
            begin : g_rest
                assign at_pos[g] = !le[g] && le[g-1];
                assign sh_pay[g] = pay_reg[g-1];
                assign sh_pri[g] = pri_reg[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign up_pay[g] = pay_reg[g];
                assign up_pri[g] = pri_reg[g];
            end
            else
            begin : g_inner
                assign up_pay[g] = pay_reg[g+1];
                assign up_pri[g] = pri_reg[g+1];
            end
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            pay_next[i] = pay_reg[i];
            pri_next[i] = pri_reg[i];
            if (cmd.push)
            begin
                priority if (le[i])
                begin
                    pay_next[i] = pay_reg[i];
                    pri_next[i] = pri_reg[i];
                end
                else if (at_pos[i])
                begin
                    pay_next[i] = ins_pay;
                    pri_next[i] = new_priority;
                end
                else
                begin
                    pay_next[i] = sh_pay[i];
                    pri_next[i] = sh_pri[i];
                end
            end
            else if (cmd.pop)
            begin
                pay_next[i] = up_pay[i];
                pri_next[i] = up_pri[i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        priority if (cmd.push)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.pop)
            count_next = count_reg - CNT_W'(1);
    end

    assign stat.full  = (count_reg == CNT_W'(CAPACITY));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            pay_reg[i] <= pay_next[i];
            pri_reg[i] <= pri_next[i];
        end
        if (cmd.load)
        begin
            head_valid_reg    <= (count_next != '0);
            head_payload_reg  <= (count_next != '0) ? head_pay_ext : '0;
            head_priority_reg <= (count_next != '0) ? pri_next[0] : '0;
            entry_count_reg   <= count_next;
            op_error_reg      <= cmd.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    assign head_valid    = head_valid_reg;
    assign head_payload  = head_payload_reg;
    assign head_priority = head_priority_reg;
    assign entry_count   = entry_count_reg;
    assign op_error      = op_error_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> count_reg == CNT_W'($past(count_reg) + CNT_W'(1)))
        else $error("push did not add one entry");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> count_reg == CNT_W'($past(count_reg) - CNT_W'(1)))
        else $error("pop did not remove one entry");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (pri_reg[0] <= pri_reg[1]))
        else $error("head cells out of order");

endmodule

/* hw/rtl/stable_priority_queue_core.sv */
// the result of a transfer is on the master side in the cycle after it is accepted
// throughput: one push or pop per cycle unless stalled; sorted cells compare in parallel
// a held result that is not taken stalls the slave side only while master tready is low
// reset (rst_n low, asynchronous): the queue is emptied and no result is pending
// stored cells are not cleared; only cells below the entry count are ever read
module stable_priority_queue_core #(
    parameter int CAPACITY      = 16,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // payload[31:0], priority_req[47:32]
    input  logic [47:0]                             s_axis_tdata,
    // opcode[0]
    input  logic                                    s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // head_valid[0], head_payload[32:1], head_priority[48:33], entry_count, op_error
    output logic [((51 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import spq_pkg::*;

    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int USED_W  = 1 + DATA_W + PRIO_W + CNT_W + ERR_W;
    localparam int OUT_W   = ((USED_W + 7) / 8) * 8;

    spq_cmd_t          cmd;
    spq_stat_t         stat;
    logic              head_valid;
    logic [DATA_W-1:0] head_payload;
    prio_t             head_priority;
    logic [CNT_W-1:0]  entry_count;
    logic [ERR_W-1:0]  op_error;

    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    spq_datapath #(
        .CAPACITY      (CAPACITY),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
        .CNT_W         (CNT_W)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .new_payload   (s_axis_tdata[DATA_W-1:0]),
        .new_priority  (s_axis_tdata[DATA_W+PRIO_W-1:DATA_W]),
        .stat          (stat),
        .head_valid    (head_valid),
        .head_payload  (head_payload),
        .head_priority (head_priority),
        .entry_count   (entry_count),
        .op_error      (op_error)
    );

    generate
        if (OUT_W > USED_W)
        begin : g_pad
            assign m_axis_tdata = {{(OUT_W-USED_W){1'b0}}, op_error, entry_count,
                                   head_priority, head_payload, head_valid};
        end
        else
        begin : g_nopad
            assign m_axis_tdata = {op_error, entry_count, head_priority, head_payload,
                                   head_valid};
        end
    endgenerate

endmodule

/* bench/tb_stable_priority_queue_core.sv */
`timescale 1ns / 100ps

module tb_stable_priority_queue_core;
    import spq_pkg::*;

    localparam int CAPACITY      = 16;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int COUNT_W       = $clog2(CAPACITY + 1);
    localparam int RES_W         = ((51 + COUNT_W + 7) / 8) * 8;
    localparam int CNT_LO        = 49;
    localparam int ERR_LO        = CNT_LO + COUNT_W;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 150;

    typedef struct {
        logic                    head_valid;
        logic [DATA_W-1:0]       head_payload;
        prio_t                   head_priority;
        logic [COUNT_W-1:0]      entry_count;
        logic [ERR_W-1:0]        op_error;
    } head_report_t;

    typedef enum int {PRIO_WIDE, PRIO_NARROW, PRIO_EDGE} prio_spread_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // payload[31:0], priority_req[47:32]
    logic [47:0]        s_axis_tdata;
    // opcode[0]
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // head_valid[0], head_payload[32:1], head_priority[48:33], entry_count, op_error
    logic [RES_W-1:0]   m_axis_tdata;

    // shadow copy of the sorted store
    logic [DATA_W-1:0]  shadow_payload [CAPACITY];
    prio_t              shadow_prio [CAPACITY];
    int                 shadow_count;

    head_report_t       expected_heads[$];
    int                 fail_count;
    int                 idle_cycles;
    bit                 tx_idle_en;
    bit                 rx_idle_en;
    int                 rx_hold_req;
    int                 rx_stall_left;

    stable_priority_queue_core #(
        .CAPACITY      (CAPACITY),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // one push or pop on the shadow store, returns the head report that follows it
    function automatic head_report_t apply_queue_op(input logic op,
                                                    input logic [DATA_W-1:0] data,
                                                    input prio_t prio);
        head_report_t rep;
        int pos;
        logic [DATA_W-1:0] kept;
        rep.op_error = ERR_NONE;
        // only the low payload bits are stored
        kept = data;
        if (PAYLOAD_WIDTH < DATA_W)
            kept = data & ((DATA_W'(1) << PAYLOAD_WIDTH) - DATA_W'(1));
        if (op == OP_PUSH)
        begin
            if (shadow_count >= CAPACITY)
            begin
                rep.op_error = ERR_FULL;
            end
            else
            begin
                pos = 0;
                // equal priorities go behind the ones already stored
                while (pos < shadow_count && shadow_prio[pos] <= prio)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_payload[i] = shadow_payload[i-1];
                    shadow_prio[i]    = shadow_prio[i-1];
                end
                shadow_payload[pos] = kept;
                shadow_prio[pos]    = prio;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
            begin
                rep.op_error = ERR_EMPTY;
            end
            else
            begin
                for (int i = 1; i < shadow_count; i++)
                begin
                    shadow_payload[i-1] = shadow_payload[i];
                    shadow_prio[i-1]    = shadow_prio[i];
                end
                shadow_count--;
            end
        end
        rep.head_valid    = (shadow_count > 0);
        rep.head_payload  = (shadow_count > 0) ? shadow_payload[0] : '0;
        rep.head_priority = (shadow_count > 0) ? shadow_prio[0] : '0;
        rep.entry_count   = shadow_count[COUNT_W-1:0];
        return rep;
    endfunction

    function automatic prio_t pick_prio(input prio_spread_t spread);
        prio_t p;
        case (spread)
            PRIO_NARROW: p = prio_t'($signed($urandom_range(0, 6)) - 3);
            PRIO_EDGE:
            begin
                case ($urandom_range(0, 6))
                    0: p = 16'sh8000;
                    1: p = 16'sh8001;
                    2: p = -16'sd1;
                    3: p = 16'sd0;
                    4: p = 16'sd1;
                    5: p = 16'sh7ffe;
                    default: p = 16'sh7fff;
                endcase
            end
            default: p = prio_t'($urandom_range(0, 65535));
        endcase
        return p;
    endfunction

    function automatic logic [DATA_W-1:0] pick_payload();
        logic [DATA_W-1:0] d;
        case ($urandom_range(0, 9))
            0: d = '0;
            1: d = '1;
            default: d = $urandom;
        endcase
        return d;
    endfunction

    // leaves tvalid high after the transfer so back-to-back items need no toggle
    task automatic send_op(input logic op, input logic [DATA_W-1:0] data, input prio_t prio);
        int gap;
        @(negedge clk);
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {prio, data};
        do @(posedge clk); while (!s_axis_tready);
        expected_heads.push_back(apply_queue_op(op, data, prio));
    endtask

    task automatic release_stream();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic test_empty_and_extremes();
        send_op(OP_POP, 32'hffff_ffff, 16'sh7fff);
        send_op(OP_PUSH, 32'hffff_ffff, 16'sh7fff);
        send_op(OP_PUSH, 32'h0000_0000, 16'sh8000);
        send_op(OP_PUSH, 32'h5555_5555, 16'sd0);
        // tie with the current head must queue behind it
        send_op(OP_PUSH, 32'haaaa_aaaa, 16'sh8000);
        send_op(OP_PUSH, 32'h1234_5678, -16'sd1);
        repeat (5)
            send_op(OP_POP, $urandom, prio_t'($urandom_range(0, 65535)));
        send_op(OP_POP, 32'h0, 16'sh8000);
    endtask

    task automatic test_fill_past_full();
        for (int i = 0; i < CAPACITY; i++)
            send_op(OP_PUSH, pick_payload(), pick_prio(PRIO_NARROW));
        // would become the head if it were taken
        send_op(OP_PUSH, 32'hdead_beef, 16'sh8000);
        send_op(OP_PUSH, 32'hffff_ffff, 16'sh7fff);
    endtask

    task automatic test_output_backpressure();
        rx_hold_req = HOLD_CYCLES;
        for (int i = 0; i < 24; i++)
            send_op(($urandom_range(0, 1) == 0) ? OP_PUSH : OP_POP,
                    pick_payload(), pick_prio(PRIO_WIDE));
    endtask

    task automatic run_mix_phase(input int n_items, input int push_pct,
                                 input prio_spread_t spread);
        logic op;
        for (int i = 0; i < n_items; i++)
        begin
            op = ($urandom_range(1, 100) <= push_pct) ? OP_PUSH : OP_POP;
            send_op(op, pick_payload(), pick_prio(spread));
        end
    endtask

    task automatic test_random_mix();
        prio_spread_t spread;
        int push_pct;
        for (int ph = 0; ph < 18; ph++)
        begin
            // fill-heavy and drain-heavy phases so the count sweeps end to end
            case (ph % 3)
                0: push_pct = 80;
                1: push_pct = 25;
                default: push_pct = 50;
            endcase
            spread = prio_spread_t'($urandom_range(0, 2));
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            run_mix_phase(40, push_pct, spread);
        end
        // closing stretch at full rate
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_mix_phase(40, 70, PRIO_NARROW);
        run_mix_phase(40, 30, PRIO_WIDE);
        release_stream();
    endtask

    // receiver: random stall bursts plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        rx_stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_hold_req > 0)
            begin
                rx_stall_left = rx_hold_req - 1;
                rx_hold_req   = 0;
                m_axis_tready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                rx_stall_left = $urandom_range(0, 11);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        head_report_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_heads.size() == 0)
            begin
                $error("result transfer with no pending operation: %0h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                exp_r = expected_heads.pop_front();
                check_field("head_valid", 32'(exp_r.head_valid), 32'(m_axis_tdata[0]));
                check_field("head_payload", exp_r.head_payload, m_axis_tdata[32:1]);
                check_field("head_priority", 32'(exp_r.head_priority[15:0]),
                            32'(m_axis_tdata[48:33]));
                check_field("entry_count", 32'(exp_r.entry_count),
                            32'(m_axis_tdata[ERR_LO-1:CNT_LO]));
                check_field("op_error", 32'(exp_r.op_error),
                            32'(m_axis_tdata[ERR_LO+ERR_W-1:ERR_LO]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PUSH;
        fail_count    = 0;
        idle_cycles   = 0;
        shadow_count  = 0;
        rx_hold_req   = 0;
        tx_idle_en    = 1'b1;
        rx_idle_en    = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_extremes();
        test_fill_past_full();
        test_output_backpressure();
        test_random_mix();

        wait (expected_heads.size() == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
